FILE: hw/rtl/sti_pkg.sv
// Shared constants, types and the constant sine ROM of the sine table interpolator.
// No dependencies; every other file of the block imports this package.

package sti_pkg;

	// Table size; a power of two so the entry index is a plain bit field.
	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int ANGLE_W = 32;
	localparam int SINE_W  = 16;
	localparam int ENTRY_W = SINE_W + 1;
	localparam int FRAC_W  = 16;
	localparam int POS_W   = FRAC_W + IDX_W;

	// Q30 angle constants used to build the ROM.
	localparam longint ONE_Q30   = 64'sd1073741824;
	localparam longint PI_Q30    = 64'sd3373259426;
	localparam longint TWOPI_Q30 = 64'sd6746518852;

	// TABLE_ENTRIES / (2*pi) in Q20.
	localparam longint unsigned SCALE =
		(longint'(TABLE_ENTRIES) << 50) / TWOPI_Q30;
	localparam int SCALE_W   = $clog2(SCALE + 1);
	localparam int POS_SHIFT = 20;
	localparam int PROD_W    = ANGLE_W + SCALE_W;
	localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(SCALE);

	// Just under one half in Q16, for the nearest-entry mode.
	localparam logic [POS_W-1:0] HALF_BELOW = POS_W'(32767);

	// Interpolation product and rounding widths.
	localparam int P_W   = ENTRY_W + ENTRY_W;
	localparam int Q_W   = P_W + 1 - FRAC_W;
	localparam int SUM_W = Q_W + 1;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [ANGLE_W-1:0]        mag_t;
	typedef logic signed [SINE_W-1:0]  sine_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic [FRAC_W-1:0]         frac_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef entry_t entry_arr_t [TABLE_ENTRIES];

	// Beat leaving the scaling stages.
	typedef struct packed {
		logic kind;
		logic neg;
		pos_t pos;
	} scale_beat_t;

	// Beat leaving the table read stage.
	typedef struct packed {
		logic   neg;
		frac_t  frac;
		entry_t sample;
		entry_t delta;
	} lookup_beat_t;

	// One ROM sample: fold into the first quadrant, odd Taylor series in Q30,
	// round half up to Q15 and clamp.
	function automatic entry_t sine_entry(input longint i);
		longint a;
		longint x2;
		longint t;
		longint v;
		longint q;
		logic   neg;
		neg = 1'b0;
		a = (TWOPI_Q30 * i) / TABLE_ENTRIES;
		if (a > PI_Q30) begin
			a = a - PI_Q30;
			neg = 1'b1;
		end
		if (a > PI_Q30 / 2)
			a = PI_Q30 - a;
		x2 = (a * a) >>> 30;
		t = ONE_Q30;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 110;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 72;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 42;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 20;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 6;
		if (t < 0)
			t = 0;
		v = (a * t) >>> 30;
		q = (v + 64'sd16384) >>> 15;
		if (neg)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return ENTRY_W'(q);
	endfunction

	function automatic entry_arr_t build_samples();
		entry_arr_t s;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			s[i] = sine_entry(longint'(i));
		return s;
	endfunction

	// Step to the next sample; the last one wraps to sin(2*pi) = 0.
	function automatic entry_arr_t build_deltas();
		entry_arr_t s;
		entry_arr_t d;
		s = build_samples();
		for (int i = 0; i < TABLE_ENTRIES - 1; i++)
			d[i] = s[i + 1] - s[i];
		d[TABLE_ENTRIES - 1] = -s[TABLE_ENTRIES - 1];
		return d;
	endfunction

	localparam entry_arr_t SAMPLE_ROM = build_samples();
	localparam entry_arr_t DELTA_ROM  = build_deltas();

endpackage

FILE: hw/rtl/sti_if.sv
// Valid/ready channel interfaces for the angle input and the sine output.
// Depends on sti_pkg for the payload types.

interface sti_in_if;
	import sti_pkg::*;
	logic   valid;
	logic   ready;
	logic   kind;
	angle_t angle;
	modport source(output valid, output kind, output angle, input ready);
	modport sink(input valid, input kind, input angle, output ready);
endinterface

interface sti_out_if;
	import sti_pkg::*;
	logic  valid;
	logic  ready;
	sine_t sine_value;
	modport source(output valid, output sine_value, input ready);
	modport sink(input valid, input sine_value, output ready);
endinterface

FILE: hw/rtl/sti_angle_scale.sv
// Stages 1 and 2: take the angle magnitude, then scale it into table units.
// Depends on sti_pkg and sti_in_if.

module sti_angle_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	sti_in_if.sink               item,
	output logic                 vld,
	input  logic                 rdy,
	output sti_pkg::scale_beat_t beat
);
	import sti_pkg::*;

	logic vld_s1;
	logic vld_s2;
	logic rdy_s1;
	logic rdy_s2;
	logic kind_s1;
	logic neg_s1;
	mag_t mag_s1;
	scale_beat_t beat_s2;
	logic [PROD_W-1:0] prod;

	assign rdy_s2 = !vld_s2 || rdy;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign item.ready = rdy_s1;

	// Stage 1: sign and magnitude; the most negative angle gives 2^31 unsigned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item.valid) begin
			kind_s1 <= item.kind;
			neg_s1  <= item.angle[ANGLE_W-1];
			mag_s1  <= item.angle[ANGLE_W-1] ? mag_t'(-item.angle) : mag_t'(item.angle);
		end
	end

	// Stage 2: multiply by the Q20 scale and keep the Q16 position mod table size.
	assign prod = PROD_W'(mag_s1) * PROD_W'(SCALE_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			beat_s2.kind <= kind_s1;
			beat_s2.neg  <= neg_s1;
			beat_s2.pos  <= prod[POS_SHIFT +: POS_W];
		end
	end

	assign vld  = vld_s2;
	assign beat = beat_s2;

endmodule

FILE: hw/rtl/sti_table_lookup.sv
// Stage 3: pick the table entry and read sample and delta from the ROM.
// Depends on sti_pkg.

module sti_table_lookup (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	output logic                  rdy_in,
	input  sti_pkg::scale_beat_t  beat_in,
	output logic                  vld,
	input  logic                  rdy,
	output sti_pkg::lookup_beat_t beat
);
	import sti_pkg::*;

	logic vld_s3;
	logic rdy_s3;
	pos_t rounded;
	idx_t idx;
	lookup_beat_t beat_s3;

	assign rdy_s3 = !vld_s3 || rdy;
	assign rdy_in = rdy_s3;

	// Nearest-entry mode adds just under one half to the position, so an exact half rounds down.
	assign rounded = beat_in.pos + HALF_BELOW;
	assign idx = beat_in.kind ? rounded[FRAC_W +: IDX_W] : beat_in.pos[FRAC_W +: IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_in;
		end
	end

	// Zero the fraction in nearest-entry mode so the interpolation term drops out.
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_in) begin
			beat_s3.neg    <= beat_in.neg;
			beat_s3.frac   <= beat_in.kind ? '0 : beat_in.pos[FRAC_W-1:0];
			beat_s3.sample <= SAMPLE_ROM[idx];
			beat_s3.delta  <= DELTA_ROM[idx];
		end
	end

	assign vld  = vld_s3;
	assign beat = beat_s3;

endmodule

FILE: hw/rtl/sti_interp.sv
// Stages 4 and 5: fraction times delta, then round, add, saturate and sign.
// Depends on sti_pkg and sti_out_if.

module sti_interp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	output logic                  rdy_in,
	input  sti_pkg::lookup_beat_t beat_in,
	sti_out_if.source             result
);
	import sti_pkg::*;

	logic vld_s4;
	logic vld_s5;
	logic rdy_s4;
	logic rdy_s5;
	logic signed [P_W-1:0] prod;
	logic signed [P_W-1:0] p_s4;
	entry_t sample_s4;
	logic   neg_s4;
	sine_t  value_s5;

	logic signed [P_W:0]   p_ext;
	logic [P_W:0]          p_abs;
	logic [P_W:0]          p_rnd;
	logic signed [Q_W-1:0] q_mag;
	logic signed [Q_W-1:0] q;
	logic signed [SUM_W-1:0] sum;
	sine_t                   sat_sum;
	logic signed [SUM_W-1:0] flipped;
	sine_t                   value;

	function automatic sine_t sat16(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(32767))
			return sine_t'(32767);
		else if (v < -SUM_W'(32768))
			return sine_t'(-32768);
		else
			return sine_t'(v);
	endfunction

	assign rdy_s5 = !vld_s5 || result.ready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_in = rdy_s4;

	// Stage 4: unsigned Q16 fraction times signed delta.
	assign prod = $signed({1'b0, beat_in.frac}) * beat_in.delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_in) begin
			p_s4      <= prod;
			sample_s4 <= beat_in.sample;
			neg_s4    <= beat_in.neg;
		end
	end

	// Stage 5: round the product half away from zero, add to the sample,
	// saturate, negate for a negative angle, saturate again.
	always_comb begin
		p_ext   = {p_s4[P_W-1], p_s4};
		p_abs   = p_s4[P_W-1] ? (P_W+1)'(-p_ext) : (P_W+1)'(p_ext);
		p_rnd   = p_abs + (P_W+1)'(32768);
		q_mag   = Q_W'(p_rnd >> FRAC_W);
		q       = p_s4[P_W-1] ? -q_mag : q_mag;
		sum     = SUM_W'(sample_s4) + SUM_W'(q);
		sat_sum = sat16(sum);
		flipped = -(SUM_W'(sat_sum));
		value   = neg_s4 ? sat16(flipped) : sat_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			value_s5 <= value;
		end
	end

	assign result.valid      = vld_s5;
	assign result.sine_value = value_s5;

endmodule

FILE: hw/rtl/sine_table_interpolator_unit.sv
// Sine table interpolator: angle in radians in, Q1.15 sine out.
// Channels: item (sink) carries kind and a signed Q15.16 angle; result (source)
// carries sine_value, signed Q1.15. A beat moves when valid and ready are high.
// kind 0 interpolates linearly between ROM entries; kind 1 takes the nearest entry.
// Pipeline: five register stages. A beat accepted into stage 1 moves through
// stages 2 to 5 in order and shows on result.valid from the stage 5 register.
// Throughput: one beat per cycle, sustained while result.ready stays high;
// the rate is set by the stage registers alone, each stage holding one beat,
// with one 32x26 multiply in stage 2 and one 17x17 multiply in stage 4.
// Stall: each stage holds while its successor is full and not draining; a
// stage with no beat still accepts, so bubbles close up and item.ready stays
// high while a finished result waits on a stalled receiver, until the five
// stages are all full.
// Reset: arst_n clears every stage valid bit at once; the ROM is constant and
// needs no fill, so the block accepts beats as soon as reset is released.
// Depends on sti_pkg, sti_if, sti_angle_scale, sti_table_lookup, sti_interp.

module sine_table_interpolator_unit (
	input  logic      clk,
	input  logic      arst_n,
	sti_in_if.sink    item,
	sti_out_if.source result
);
	import sti_pkg::*;

	// Scaling stages to table read.
	logic         scale_vld;
	logic         scale_rdy;
	scale_beat_t  scale_beat;

	// Table read to interpolation.
	logic         lookup_vld;
	logic         lookup_rdy;
	lookup_beat_t lookup_beat;

	// Stages 1-2: magnitude and sign, then scale to table units.
	sti_angle_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.vld    (scale_vld),
		.rdy    (scale_rdy),
		.beat   (scale_beat)
	);

	// Stage 3: entry index (truncated or rounded) and ROM read.
	sti_table_lookup u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (scale_vld),
		.rdy_in  (scale_rdy),
		.beat_in (scale_beat),
		.vld     (lookup_vld),
		.rdy     (lookup_rdy),
		.beat    (lookup_beat)
	);

	// Stages 4-5: interpolate, saturate, apply sign, hold the output beat.
	sti_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (lookup_vld),
		.rdy_in  (lookup_rdy),
		.beat_in (lookup_beat),
		.result  (result)
	);

endmodule
